[sv/tkcs_pkg.sv]
// tkcs_pkg: shared types and constants for the top-k count selector
// no dependencies
`timescale 1ns / 1ps
package tkcs_pkg;
   localparam int CAPACITY = 64;
   localparam int FP_SIZE = 6;
   localparam int FP_W = 8 * FP_SIZE;
   localparam int CNT_W = 64;
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int OCC_W = ADDR_W + 1;
   localparam logic [6:0] KEEP_RESET = 7'd50;

   typedef struct packed {
      logic [FP_W-1:0]  fingerprint;
      logic [CNT_W-1:0] count;
      logic             last_entry;
   } req_type;

   typedef struct packed {
      logic [FP_W-1:0]  out_fingerprint;
      logic [CNT_W-1:0] out_count;
      logic             out_last;
   } rsp_type;

   typedef struct packed {
      logic [FP_W-1:0]  fingerprint;
      logic [CNT_W-1:0] count;
   } entry_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      entry_type         wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;
endpackage

[sv/tkcs_store.sv]
// tkcs_store: sorted entry store, one write and one registered read per cycle
// depends on tkcs_pkg
`timescale 1ns / 1ps
module tkcs_store import tkcs_pkg::*; (
   input  logic        clock,
   input  mem_req_type mem_req,
   output entry_type   rd_data
);
   entry_type mem [CAPACITY];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data_ff <= mem[mem_req.rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[sv/top_k_count_selector.sv]
// top_k_count_selector: keeps the largest-count entries of a run, emits them sorted
// insertion shifts held entries one step at a time (one store read in S_STEP plus compare in S_CMP),
// and no new item is taken until it ends; results are read out one by one via S_LOAD and S_EMIT
// synchronous active-high reset: keep_count returns to 50, store empty; contents stay undefined
// depends on tkcs_pkg and tkcs_store
`timescale 1ns / 1ps
module top_k_count_selector import tkcs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [6:0] csr_wdata
);
   typedef enum logic [2:0] {
      S_IDLE, S_CHK, S_STEP, S_CMP, S_DONE, S_LOAD, S_EMIT
   } state_type;

   state_type         state_ff;
   logic [6:0]        keep_ff;
   logic [OCC_W-1:0]  occ_ff;
   logic [OCC_W-1:0]  hole_ff;
   logic [ADDR_W-1:0] idx_ff;
   logic              grow_ff;
   req_type           item_ff;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;

   logic [OCC_W-1:0]  keep_eff;
   mem_req_type       mem_req;
   entry_type         rd_data;
   logic [OCC_W-1:0]  occ_m1;

   tkcs_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   always_comb begin
      if (keep_ff == 7'd0) keep_eff = OCC_W'(1);
      else if ({1'b0, keep_ff} > 8'(CAPACITY)) keep_eff = OCC_W'(CAPACITY);
      else keep_eff = OCC_W'(keep_ff);
   end

   assign occ_m1 = occ_ff - OCC_W'(1);
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      mem_req.wr_en = 1'b0;
      mem_req.wr_addr = hole_ff[ADDR_W-1:0];
      mem_req.wr_data = '{fingerprint: item_ff.fingerprint, count: item_ff.count};
      mem_req.rd_addr = '0;
      unique case (state_ff)
         S_IDLE: mem_req.rd_addr = occ_m1[ADDR_W-1:0];
         S_STEP: mem_req.rd_addr = ADDR_W'(hole_ff - OCC_W'(1));
         S_CMP: begin
            mem_req.wr_en = 1'b1;
            if (rd_data.count < item_ff.count) mem_req.wr_data = rd_data;
         end
         S_DONE: mem_req.rd_addr = '0;
         S_EMIT: mem_req.rd_addr = idx_ff + ADDR_W'(1);
         default: mem_req.wr_en = (state_ff == S_STEP) && (hole_ff == '0);
      endcase
      if (state_ff == S_STEP && hole_ff == '0) mem_req.wr_en = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         keep_ff <= KEEP_RESET;
         occ_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) keep_ff <= csr_wdata;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  item_ff <= req_data;
                  if (occ_ff < keep_eff) begin
                     hole_ff <= occ_ff;
                     grow_ff <= 1'b1;
                     state_ff <= S_STEP;
                  end else begin
                     grow_ff <= 1'b0;
                     state_ff <= S_CHK;
                  end
               end
            end
            // full store: replace the tail only on a strictly larger count
            S_CHK: begin
               if (item_ff.count > rd_data.count) begin
                  hole_ff <= occ_m1;
                  state_ff <= S_STEP;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_STEP: begin
               if (hole_ff == '0) begin
                  if (grow_ff) occ_ff <= occ_ff + OCC_W'(1);
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_CMP;
               end
            end
            // equal counts stay ahead: arrival order
            S_CMP: begin
               if (rd_data.count >= item_ff.count) begin
                  if (grow_ff) occ_ff <= occ_ff + OCC_W'(1);
                  state_ff <= S_DONE;
               end else begin
                  hole_ff <= hole_ff - OCC_W'(1);
                  state_ff <= S_STEP;
               end
            end
            S_DONE: begin
               idx_ff <= '0;
               state_ff <= item_ff.last_entry ? S_LOAD : S_IDLE;
            end
            S_LOAD: begin
               rsp_ff.out_fingerprint <= rd_data.fingerprint;
               rsp_ff.out_count <= rd_data.count;
               rsp_ff.out_last <= (OCC_W'(idx_ff) == occ_m1);
               rsp_valid_ff <= 1'b1;
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (OCC_W'(idx_ff) == occ_m1) begin
                     occ_ff <= '0;
                     state_ff <= S_IDLE;
                  end else begin
                     idx_ff <= idx_ff + ADDR_W'(1);
                     state_ff <= S_LOAD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
